FILE: rtl/assert_macros.svh
// Assertion macros used by the circular FIFO module.
// Depends on: nothing; the using module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression never holds, skipped while rst is high.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/cfs_pkg.sv
// Package for the circular FIFO with search: field widths, request and status codes.
// Depends on: nothing.
`timescale 1ns / 1ps

package cfs_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int REQ_W   = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 4;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam req_t REQ_PUSH   = 3'd0;
  localparam req_t REQ_POP    = 3'd1;
  localparam req_t REQ_READ   = 3'd2;
  localparam req_t REQ_SEARCH = 3'd3;
  localparam req_t REQ_CLEAR  = 3'd4;

  localparam stat_t ST_OK       = 3'd0;
  localparam stat_t ST_FULL     = 3'd1;
  localparam stat_t ST_EMPTY    = 3'd2;
  localparam stat_t ST_RANGE    = 3'd3;
  localparam stat_t ST_NOTFOUND = 3'd4;

endpackage

FILE: rtl/circular_fifo_with_search.sv
// Ring-buffer FIFO of signed 32-bit words with position read and value search.
// Push, pop, read, clear and bad codes: accepted in S_IDLE, result registered from S_EXEC
// once the result register is free; no new request is taken until then. Search: one entry
// a cycle from the head in S_SCAN, ending on the first hit or on the last held entry; no new
// request is taken until its result is loaded. A stalled result holds the sequencer, and with it the request side.
// Synchronous active-high reset empties the ring (head = tail = 0); slot contents stay undefined.
`timescale 1ns / 1ps

module circular_fifo_with_search
  import cfs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] data,
  output logic [POS_W-1:0]         found_position,
  output logic [CNT_W-1:0]         count,
  output logic                     is_empty
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W > POS_W) ? PTR_W : POS_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take a request, launch the first RAM read
  localparam logic [1:0] S_EXEC = 2'd1;  // finish a single-step request
  localparam logic [1:0] S_SCAN = 2'd2;  // compare one entry a cycle for a search

  // Ring pointers wrap at DEPTH, which need not be a power of two.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    ring_next = (i == PTR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]              state, state_next;
  logic [PTR_W-1:0]        head, head_next;
  logic [PTR_W-1:0]        tail, tail_next;
  logic [PTR_W-1:0]        fill, fill_next;     // entries held, kept alongside the pointers
  logic [PTR_W-1:0]        scan_k, scan_k_next; // index from head of the word in rd_data
  logic [PTR_W-1:0]        scan_addr, scan_addr_next;

  // Latched request
  req_t                    req_kind;
  logic signed [DATA_W-1:0] req_value;
  logic [POS_W-1:0]        req_position;

  // RAM port
  logic                    mem_we;
  logic                    rd_en;
  logic [PTR_W-1:0]        rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  // Result being loaded
  logic                    res_load;
  stat_t                   res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [POS_W-1:0]        res_found;

  logic                    out_free;
  logic [PTR_W:0]          pos_sum;
  logic [PTR_W-1:0]        pos_addr;
  logic                    hit;
  logic                    last;
  logic [PTR_W-1:0]        scan_k_inc;
  logic                    pos_bad;

  assign out_free = !out_valid || !out_stall;

  // Slot of the 1-based position from head; the sum stays below 2*DEPTH for a legal position.
  always_comb begin
    pos_sum = {1'b0, head} + (PTR_W + 1)'(position) - (PTR_W + 1)'(1);
    if (pos_sum >= (PTR_W + 1)'(DEPTH)) begin
      pos_sum = pos_sum - (PTR_W + 1)'(DEPTH);
    end
    pos_addr = pos_sum[PTR_W-1:0];
  end

  assign pos_bad    = (req_position == '0) || (CMP_W'(req_position) > CMP_W'(fill));
  assign hit        = (rd_data == req_value);
  assign scan_k_inc = scan_k + 1'b1;
  assign last       = (scan_k_inc == fill);

  cfs_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W),
    .WIDTH  (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (req_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    in_stall       = 1'b1;
    rd_en          = 1'b0;
    rd_addr        = head;
    mem_we         = 1'b0;
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    scan_k_next    = scan_k;
    scan_addr_next = scan_addr;
    res_load       = 1'b0;
    res_status     = ST_OK;
    res_data       = '0;
    res_found      = '0;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // Launch the read now so the word is ready next cycle.
          rd_en = 1'b1;
          if (req_type == REQ_READ) begin
            rd_addr = pos_addr;
          end
          if (req_type == REQ_SEARCH && fill != '0) begin
            state_next     = S_SCAN;
            scan_k_next    = '0;
            scan_addr_next = ring_next(head);
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          unique case (req_kind)
            REQ_PUSH: begin
              if (fill == PTR_W'(DEPTH - 1)) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                tail_next = ring_next(tail);
                fill_next = fill + 1'b1;
              end
            end
            REQ_POP: begin
              if (fill == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_data  = rd_data;
                head_next = ring_next(head);
                fill_next = fill - 1'b1;
              end
            end
            REQ_READ: begin
              if (pos_bad) begin
                res_status = ST_RANGE;
              end else begin
                res_data = rd_data;
              end
            end
            REQ_SEARCH: begin
              // Only an empty ring lands here.
              res_status = ST_EMPTY;
            end
            REQ_CLEAR: begin
              tail_next = head;
              fill_next = '0;
            end
            default: begin
              res_status = ST_RANGE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || last) begin
          // Hold rd_data until the result register frees up.
          if (out_free) begin
            res_load   = 1'b1;
            state_next = S_IDLE;
            if (hit) begin
              res_status = ST_OK;
              res_found  = POS_W'(scan_k_inc);
            end else begin
              res_status = ST_NOTFOUND;
            end
          end
        end else begin
          // Advance to the next entry.
          rd_en          = 1'b1;
          rd_addr        = scan_addr;
          scan_addr_next = ring_next(scan_addr);
          scan_k_next    = scan_k_inc;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: latched request, scan position, result word
  always_ff @(posedge clk) begin
    scan_k    <= scan_k_next;
    scan_addr <= scan_addr_next;
    if (in_valid && !in_stall) begin
      req_kind     <= req_type;
      req_value    <= value;
      req_position <= position;
    end
    if (res_load) begin
      status         <= res_status;
      data           <= res_data;
      found_position <= res_found;
      count          <= CNT_W'(fill_next);
      is_empty       <= (fill_next == '0);
    end
  end

  // The fill count matches the pointer distance around the ring.
  `ASSERT_CLK(a_fill_matches_ptrs, (tail >= head) ? (fill == tail - head) : (PTR_W + 1)'(fill) == (PTR_W + 1)'(DEPTH) + (PTR_W + 1)'(tail) - (PTR_W + 1)'(head), "fill count disagrees with head and tail")
  // A new result is only loaded from a working state.
  `ASSERT_CLK(a_result_from_work, $rose(out_valid) |-> ($past(state) == S_EXEC || $past(state) == S_SCAN), "result appeared without a request in progress")
  // The scan never looks past the last held entry.
  `ASSERT_CLK(a_scan_in_range, (state == S_SCAN) |-> (scan_k < fill), "search index ran past the held entries")
  // The RAM is written only when a push completes.
  `ASSERT_CLK(a_write_on_push, mem_we |-> (state == S_EXEC && req_kind == REQ_PUSH && res_load), "slot write outside a push")

endmodule

FILE: rtl/cfs_ram.sv
// Simple dual-port RAM for the FIFO slots: one write port, one registered read port.
// Depends on: cfs_pkg (default depth and data width).
`timescale 1ns / 1ps

module cfs_ram
  import cfs_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int WIDTH  = DATA_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [WIDTH-1:0]  wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [WIDTH-1:0]  rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
